@@ hdl/oar_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// oar_pkg
// Shared widths, event codes, motion constants and types for the
// obstacle-avoidance reflex.
// ============================================================================
package oar_pkg;

    localparam int READ_W  = 8;
    localparam int HALF_W  = READ_W - 1;
    localparam int LEVEL_W = 8;
    localparam int EVENT_W = 3;
    localparam int POS_W   = 3;
    localparam int SPEED_W = 6;
    localparam int LED_W   = 4;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 4 * READ_W;
    localparam int OUT_DATA_W = 32;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 2'd2;

    // Reset thresholds
    localparam logic [CFG_W-1:0] DETECT_RESET = 8'd25;
    localparam logic [CFG_W-1:0] CLEAR_RESET  = 8'd20;
    localparam logic [CFG_W-1:0] SIDE_RESET   = 8'd5;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EVENT_W-1:0] EV_KEY         = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DETECTED    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_CLEAR       = 3'd3;
    localparam logic [EVENT_W-1:0] EV_CLEAR_LEFT  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_CLEAR_RIGHT = 3'd5;

    // Motor speed commands
    localparam logic signed [SPEED_W-1:0] SPD_STOP    = 6'sd0;
    localparam logic signed [SPEED_W-1:0] SPD_REVERSE = -6'sd25;
    localparam logic signed [SPEED_W-1:0] SPD_TURN    = 6'sd15;
    localparam logic signed [SPEED_W-1:0] SPD_BACKUP  = -6'sd20;
    localparam logic signed [SPEED_W-1:0] SPD_CRUISE  = 6'sd30;
    localparam logic signed [SPEED_W-1:0] SPD_VEER    = 6'sd20;

    // LED patterns
    localparam logic [LED_W-1:0] LED_STOPPED     = 4'b1001;
    localparam logic [LED_W-1:0] LED_CLEAR       = 4'b0000;
    localparam logic [LED_W-1:0] LED_CLEAR_LEFT  = 4'b0100;
    localparam logic [LED_W-1:0] LED_CLEAR_RIGHT = 4'b0010;

    // Classification of one sensor sample
    typedef struct packed {
        logic [EVENT_W-1:0]      formed;
        logic signed [POS_W-1:0] pos;
        logic [LEVEL_W-1:0]      level;
    } sense_t;

    // One result beat, lowest field in the lowest bits
    typedef struct packed {
        logic                      pad;
        logic                      running;
        logic [LED_W-1:0]          led_pattern;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
        logic [LEVEL_W-1:0]        obstacle_level;
        logic signed [POS_W-1:0]   obstacle_position;
        logic [EVENT_W-1:0]        event_code;
    } result_t;

endpackage

@@ hdl/obstacle_avoidance_reflex.sv @@
`timescale 1ns / 1ps
// ============================================================================
// obstacle_avoidance_reflex
// Proximity-driven avoidance reflex: key presses start and stop it, sensor
// beats set motor speeds and LEDs.
// ============================================================================
// Each input beat is registered in the input register, then classified and
// resolved against the held state, and its result lands in the output
// register, so one beat is accepted per clock while the output is not stalled,
// and its result is presented on m_tdata once the output register loads it.
// The only wait is back-pressure: the input register holds while the output
// register is full and m_tready is low. Thresholds are written through the cfg
// channel (index 0 detect, 1 clear, 2 side; other indexes are ignored) and
// should only change while no beat is in flight.
module obstacle_avoidance_reflex import oar_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sensor / key channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] far_left_reading, [15:8] near_left_reading,
    // [23:16] near_right_reading, [31:24] far_right_reading
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] cmd (1 key press, 0 sensor sample)
    input  logic                  s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] event_code, [5:3] obstacle_position, [13:6] obstacle_level,
    // [19:14] left_speed, [25:20] right_speed, [29:26] led_pattern,
    // [30] running, [31] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    logic                 advance;
    logic [CFG_W-1:0]     detect_reg, clear_reg, side_reg;
    sense_t               sense;
    result_t              result;

    // Pipeline handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // Threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_reg <= DETECT_RESET;
            clear_reg  <= CLEAR_RESET;
            side_reg   <= SIDE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DETECT: detect_reg <= cfg_data;
                CFG_CLEAR:  clear_reg  <= cfg_data;
                CFG_SIDE:   side_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    oar_classify u_classify (
        .far_left_reading   (in_data_reg[READ_W-1:0]),
        .near_left_reading  (in_data_reg[2*READ_W-1:READ_W]),
        .near_right_reading (in_data_reg[3*READ_W-1:2*READ_W]),
        .far_right_reading  (in_data_reg[4*READ_W-1:3*READ_W]),
        .detect_level       (detect_reg),
        .clear_level        (clear_reg),
        .side_level         (side_reg),
        .sense              (sense)
    );

    oar_control u_control (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cmd     (in_cmd_reg),
        .sense   (sense),
        .result  (result)
    );

    // Output register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

@@ hdl/oar_classify.sv @@
`timescale 1ns / 1ps
// ============================================================================
// oar_classify
// Reduces four proximity readings to an obstacle level and position and
// forms the threshold event.
// ============================================================================
module oar_classify import oar_pkg::*; (
    input  logic [READ_W-1:0] far_left_reading,
    input  logic [READ_W-1:0] near_left_reading,
    input  logic [READ_W-1:0] near_right_reading,
    input  logic [READ_W-1:0] far_right_reading,
    input  logic [CFG_W-1:0]  detect_level,
    input  logic [CFG_W-1:0]  clear_level,
    input  logic [CFG_W-1:0]  side_level,
    output sense_t            sense
);

    logic [HALF_W-1:0]  fl, nl, nr, fr;
    logic [LEVEL_W-1:0] ls, cs, rs;
    logic [LEVEL_W-1:0] lr_max, level;
    logic signed [POS_W-1:0] pos;
    logic [EVENT_W-1:0] formed;

    // Halve readings and form the three sums
    always_comb begin
        fl = far_left_reading[READ_W-1:1];
        nl = near_left_reading[READ_W-1:1];
        nr = near_right_reading[READ_W-1:1];
        fr = far_right_reading[READ_W-1:1];
        ls = {1'b0, fl} + {1'b0, nl};
        cs = {1'b0, nl} + {1'b0, nr};
        rs = {1'b0, fr} + {1'b0, nr};
    end

    // Take the maximum and locate the obstacle
    always_comb begin
        lr_max = (ls >= rs) ? ls : rs;
        level  = (cs > lr_max) ? cs : lr_max;
        if ((level == cs) || (ls == rs)) begin
            if (ls > rs)      pos = -3'sd1;
            else if (ls < rs) pos = 3'sd1;
            else              pos = 3'sd0;
        end else begin
            pos = (ls > rs) ? -3'sd2 : 3'sd2;
        end
    end

    // Compare with thresholds; clear wins over detected
    always_comb begin
        formed = EV_NONE;
        if (level > detect_level) formed = EV_DETECTED;
        if (level < clear_level) begin
            formed = EV_CLEAR;
            if (level > side_level) begin
                if (pos[POS_W-1])     formed = EV_CLEAR_RIGHT;
                else if (pos != 3'sd0) formed = EV_CLEAR_LEFT;
            end
        end
    end

    assign sense.formed = formed;
    assign sense.pos    = pos;
    assign sense.level  = level;

endmodule

@@ hdl/oar_control.sv @@
`timescale 1ns / 1ps
// ============================================================================
// oar_control
// Holds run state, last event, motor speeds and LEDs; forms the result
// for the item currently in the input register.
// ============================================================================
module oar_control import oar_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  logic    cmd,
    input  sense_t  sense,
    output result_t result
);

    logic                      run_reg, run_next;
    logic [EVENT_W-1:0]        prev_reg, prev_next;
    logic signed [SPEED_W-1:0] left_reg, left_next;
    logic signed [SPEED_W-1:0] right_reg, right_next;
    logic [LED_W-1:0]          leds_reg, leds_next;
    logic [EVENT_W-1:0]        ev;
    logic                      pos_neg, pos_pos;

    assign pos_neg = sense.pos[POS_W-1];
    assign pos_pos = !sense.pos[POS_W-1] && (sense.pos != 3'sd0);

    // Next state and reported event
    always_comb begin
        run_next   = run_reg;
        prev_next  = prev_reg;
        left_next  = left_reg;
        right_next = right_reg;
        leds_next  = leds_reg;
        ev         = EV_NONE;
        if (cmd) begin
            ev = EV_KEY;
            if (!run_reg) begin
                run_next  = 1'b1;
                prev_next = EV_NONE;
            end else begin
                run_next   = 1'b0;
                left_next  = SPD_STOP;
                right_next = SPD_STOP;
                leds_next  = LED_STOPPED;
            end
        end else begin
            if (sense.formed != prev_reg) begin
                prev_next = sense.formed;
                ev        = sense.formed;
            end
            if (run_reg) begin
                unique case (ev)
                    EV_DETECTED: begin
                        leds_next = {!pos_neg, 2'b00, !pos_pos};
                        if (pos_pos) begin
                            left_next  = SPD_REVERSE;
                            right_next = SPD_TURN;
                        end else if (pos_neg) begin
                            left_next  = SPD_TURN;
                            right_next = SPD_REVERSE;
                        end else begin
                            left_next  = SPD_BACKUP;
                            right_next = SPD_BACKUP;
                        end
                    end
                    EV_CLEAR: begin
                        left_next  = SPD_CRUISE;
                        right_next = SPD_CRUISE;
                        leds_next  = LED_CLEAR;
                    end
                    EV_CLEAR_LEFT: begin
                        left_next  = SPD_VEER;
                        right_next = SPD_CRUISE;
                        leds_next  = LED_CLEAR_LEFT;
                    end
                    EV_CLEAR_RIGHT: begin
                        left_next  = SPD_CRUISE;
                        right_next = SPD_VEER;
                        leds_next  = LED_CLEAR_RIGHT;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            prev_reg  <= EV_NONE;
            left_reg  <= SPD_STOP;
            right_reg <= SPD_STOP;
            leds_reg  <= '0;
        end else if (advance) begin
            run_reg   <= run_next;
            prev_reg  <= prev_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            leds_reg  <= leds_next;
        end
    end

    // Assemble the result beat; key presses carry no position or level
    always_comb begin
        result.pad               = 1'b0;
        result.running           = run_next;
        result.led_pattern       = leds_next;
        result.right_speed       = right_next;
        result.left_speed        = left_next;
        result.obstacle_level    = cmd ? '0 : sense.level;
        result.obstacle_position = cmd ? 3'sd0 : sense.pos;
        result.event_code        = ev;
    end

endmodule

@@ tb/obstacle_avoidance_reflex_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// obstacle_avoidance_reflex_checker
// Watches the sensor, result and configuration channels of the avoidance
// reflex, predicts every result beat and compares it field by field.
// ============================================================================
// Every accepted input beat produces exactly one result. The predictor keeps
// its own thresholds, run state, last reported event and held motion, and
// queues the expected result. Result beats are matched in order against the
// queue. The number of outstanding results is published through a nonblocking
// assignment, so the stimulus can read it at an edge without racing this block.
module obstacle_avoidance_reflex_checker import oar_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    // Thresholds as last written
    logic [CFG_W-1:0] th_detect;
    logic [CFG_W-1:0] th_clear;
    logic [CFG_W-1:0] th_side;

    // Behavior state
    logic                      engaged;
    logic [EVENT_W-1:0]        last_event;
    logic signed [SPEED_W-1:0] hold_left;
    logic signed [SPEED_W-1:0] hold_right;
    logic [LED_W-1:0]          hold_leds;

    result_t motion_q[$];
    result_t want;
    result_t seen;
    int      fail_total = 0;

    assign mismatches = fail_total;

    // Latch the held motor speeds and LED pattern
    function automatic void steer(input logic signed [SPEED_W-1:0] lft,
                                  input logic signed [SPEED_W-1:0] rgt,
                                  input logic [LED_W-1:0] leds);
        hold_left  = lft;
        hold_right = rgt;
        hold_leds  = leds;
    endfunction

    // Work out the result of one beat and advance the behavior state
    function automatic result_t predict_reflex(input logic key,
                                               input logic [IN_DATA_W-1:0] rd);
        int fl, nl, nr, fr;
        int ls, cs, rs, lvl, pos;
        logic [EVENT_W-1:0] formed;
        logic [EVENT_W-1:0] ev;
        logic [LED_W-1:0]   leds;
        result_t r;
        ev  = EV_NONE;
        pos = 0;
        lvl = 0;
        if (key) begin
            ev = EV_KEY;
            if (!engaged) begin
                // start: forget the last event so the next one is reported
                engaged    = 1'b1;
                last_event = EV_NONE;
            end else begin
                engaged = 1'b0;
                steer(SPD_STOP, SPD_STOP, LED_STOPPED);
            end
        end else begin
            // halve the readings, form the three sums and take the largest
            fl = int'(rd[7:1]);
            nl = int'(rd[15:9]);
            nr = int'(rd[23:17]);
            fr = int'(rd[31:25]);
            ls = fl + nl;
            cs = nl + nr;
            rs = fr + nr;
            lvl = ls;
            if (cs > lvl) lvl = cs;
            if (rs > lvl) lvl = rs;

            if (lvl == cs || ls == rs)
                pos = (ls > rs) ? -1 : (ls < rs) ? 1 : 0;
            else
                pos = (ls > rs) ? -2 : 2;

            // classify; the clear test overrides the detect test
            formed = EV_NONE;
            if (lvl > int'(th_detect)) formed = EV_DETECTED;
            if (lvl < int'(th_clear)) begin
                formed = EV_CLEAR;
                if (lvl > int'(th_side)) begin
                    if (pos < 0)      formed = EV_CLEAR_RIGHT;
                    else if (pos > 0) formed = EV_CLEAR_LEFT;
                end
            end

            // report only a change of event
            if (formed != last_event) begin
                last_event = formed;
                ev         = formed;
            end

            if (engaged) begin
                case (ev)
                    EV_DETECTED: begin
                        leds = '0;
                        if (pos <= 0) leds[0] = 1'b1;
                        if (pos >= 0) leds[3] = 1'b1;
                        if (pos > 0)      steer(SPD_REVERSE, SPD_TURN, leds);
                        else if (pos < 0) steer(SPD_TURN, SPD_REVERSE, leds);
                        else              steer(SPD_BACKUP, SPD_BACKUP, leds);
                    end
                    EV_CLEAR:       steer(SPD_CRUISE, SPD_CRUISE, LED_CLEAR);
                    EV_CLEAR_LEFT:  steer(SPD_VEER, SPD_CRUISE, LED_CLEAR_LEFT);
                    EV_CLEAR_RIGHT: steer(SPD_CRUISE, SPD_VEER, LED_CLEAR_RIGHT);
                    default: ;
                endcase
            end
        end

        r.pad               = 1'b0;
        r.running           = engaged;
        r.led_pattern       = hold_leds;
        r.right_speed       = hold_right;
        r.left_speed        = hold_left;
        r.obstacle_level    = lvl[LEVEL_W-1:0];
        r.obstacle_position = pos[POS_W-1:0];
        r.event_code        = ev;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_total++;
        end
    endtask

    // Compare result beats, track register writes, queue predictions
    always @(posedge aclk) begin
        if (!aresetn) begin
            th_detect  = DETECT_RESET;
            th_clear   = CLEAR_RESET;
            th_side    = SIDE_RESET;
            engaged    = 1'b0;
            last_event = EV_NONE;
            hold_left  = SPD_STOP;
            hold_right = SPD_STOP;
            hold_leds  = '0;
            motion_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (motion_q.size() == 0) begin
                    $error("result beat %h with no expected result", m_tdata);
                    fail_total++;
                end else begin
                    want = motion_q.pop_front();
                    seen = result_t'(m_tdata);
                    check_field("event_code", int'(want.event_code),
                                int'(seen.event_code));
                    check_field("obstacle_position", int'(want.obstacle_position),
                                int'(seen.obstacle_position));
                    check_field("obstacle_level", int'(want.obstacle_level),
                                int'(seen.obstacle_level));
                    check_field("left_speed", int'(want.left_speed),
                                int'(seen.left_speed));
                    check_field("right_speed", int'(want.right_speed),
                                int'(seen.right_speed));
                    check_field("led_pattern", int'(want.led_pattern),
                                int'(seen.led_pattern));
                    check_field("running", int'(want.running), int'(seen.running));
                    check_field("pad", int'(want.pad), int'(seen.pad));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DETECT: th_detect = cfg_data;
                    CFG_CLEAR:  th_clear  = cfg_data;
                    CFG_SIDE:   th_side   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                motion_q.push_back(predict_reflex(s_tuser, s_tdata));
        end
        outstanding <= motion_q.size();
    end

endmodule

@@ tb/tb_obstacle_avoidance_reflex.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_obstacle_avoidance_reflex
// Stimulus and verdict for the obstacle-avoidance reflex.
// ============================================================================
// A short directed run walks through start and stop by key, every event,
// every obstacle position, repeated events, samples between the thresholds,
// samples while stopped and overlapping thresholds. Random beats follow under
// six threshold settings and three idling patterns: sender gaps light with
// heavy back-pressure, then the reverse, then none at all. The checker does
// the prediction; this module drives the channels and reports the outcome.
module tb_obstacle_avoidance_reflex import oar_pkg::*; ();

    localparam int                   QUIET_LIMIT = 2000;
    localparam int                   TAIL_CYCLES = 4;
    localparam int                   CHUNK_BEATS = 230;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int mismatches;
    int outstanding;
    int gap_pct   = 11;
    int stall_pct = 67;
    int quiet_cycles = 0;

    logic [IN_DATA_W-1:0] last_sample = '0;

    // detect, clear and side levels for each random chunk
    logic [CFG_W-1:0] level_plan [6][3] = '{
        '{8'd25,  8'd20,  8'd5},
        '{8'd255, 8'd255, 8'd255},
        '{8'd0,   8'd0,   8'd0},
        '{8'd10,  8'd200, 8'd3},
        '{8'd60,  8'd40,  8'd20},
        '{8'd0,   8'd255, 8'd0}
    };

    obstacle_avoidance_reflex DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    obstacle_avoidance_reflex_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Back-pressure on the result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Abort when no channel moves a beat for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one beat after a random gap and hold it until taken
    task automatic send_beat(input logic key, input logic [IN_DATA_W-1:0] rd);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= key;
        s_tdata  <= rd;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all thresholds, plus a stray write to the unused index
    task automatic program_levels(input logic [CFG_W-1:0] det,
                                  input logic [CFG_W-1:0] clr,
                                  input logic [CFG_W-1:0] side);
        write_reg(CFG_DETECT, det);
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        write_reg(CFG_CLEAR, clr);
        write_reg(CFG_SIDE, side);
        cfg_valid <= 1'b0;
    endtask

    // Random key press or sample, biased toward the threshold region
    task automatic send_random_beat;
        logic [IN_DATA_W-1:0] rd;
        int hot;
        rd = IN_DATA_W'($urandom);
        if ($urandom_range(99) < 7) begin
            send_beat(1'b1, rd);
        end else begin
            case ($urandom_range(3))
                0: ;
                1: for (int i = 0; i < 4; i++)
                       rd[i*READ_W +: READ_W] = READ_W'($urandom_range(60));
                2: begin
                    hot = int'($urandom_range(3));
                    for (int i = 0; i < 4; i++)
                        rd[i*READ_W +: READ_W] = (i == hot) ? READ_W'($urandom_range(80))
                                                            : READ_W'($urandom_range(3));
                end
                default: rd = last_sample;
            endcase
            last_sample = rd;
            send_beat(1'b0, rd);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_levels(DETECT_RESET, CLEAR_RESET, SIDE_RESET);

        // clear while stopped, then start
        send_beat(1'b0, '0);
        send_beat(1'b1, IN_DATA_W'($urandom));
        // clear again after start, then a repeat
        send_beat(1'b0, '0);
        send_beat(1'b0, '0);
        // centre detected at full scale
        send_beat(1'b0, {4{8'hFF}});
        // clear to the right, then detected far left
        send_beat(1'b0, {8'd0, 8'd0, 8'd0, 8'd21});
        send_beat(1'b0, {8'd0, 8'd0, 8'd0, 8'd101});
        // clear to the left, then detected near right
        send_beat(1'b0, {8'd21, 8'd0, 8'd0, 8'd0});
        send_beat(1'b0, {8'd0, 8'd60, 8'd40, 8'd0});
        // clear, detected near left, repeated detect far right
        send_beat(1'b0, '0);
        send_beat(1'b0, {8'd0, 8'd40, 8'd60, 8'd0});
        send_beat(1'b0, {8'd101, 8'd0, 8'd0, 8'd0});
        // between the thresholds, then clear too faint to name a side
        send_beat(1'b0, {8'd0, 8'd0, 8'd0, 8'd45});
        send_beat(1'b0, {8'd0, 8'd0, 8'd0, 8'd9});
        // stop, samples while stopped, start, stop, start
        send_beat(1'b1, '0);
        send_beat(1'b0, {4{8'hFF}});
        send_beat(1'b0, '0);
        send_beat(1'b1, {4{8'hFF}});
        send_beat(1'b1, '0);
        send_beat(1'b1, IN_DATA_W'($urandom));

        // overlapping thresholds: clear wins over detect
        drain();
        program_levels(8'd0, 8'd255, 8'd0);
        send_beat(1'b0, {8'd0, 8'd0, 8'd0, 8'd21});
        send_beat(1'b0, {4{8'hFF}});
        send_beat(1'b0, '0);

        for (int chunk = 0; chunk < 6; chunk++) begin
            drain();
            gap_pct   = (chunk < 2) ? 11 : (chunk < 4) ? 67 : 0;
            stall_pct = (chunk < 2) ? 67 : (chunk < 4) ? 11 : 0;
            program_levels(level_plan[chunk][0], level_plan[chunk][1],
                           level_plan[chunk][2]);
            repeat (CHUNK_BEATS) send_random_beat();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
